// ===== rtl/bgi_pkg.sv =====
// Shared types and constants of the block gain interpolator.
package bgi_pkg;

   // Table and time geometry.
   localparam int MAX_BLOCKS = 1024;
   localparam int BLOCK_BITS = $clog2(MAX_BLOCKS);
   localparam int TIME_BITS  = 24;

   // Q16.16 constants.
   localparam logic signed [31:0] Q_ONE  = 32'sd65536;
   localparam logic signed [31:0] Q_ZERO = 32'sd0;

   // Section number stops counting here.
   localparam logic [10:0] SECTION_MAX = 11'd2047;

   // Interpolation datapath widths.
   localparam int M_BITS    = 29;
   localparam int DEN_BITS  = 26;
   localparam int QUO_BITS  = 62;
   localparam int STEP_BITS = $clog2(QUO_BITS);
   localparam int X2_BITS   = 28;

   // One table entry as stored in the memory.
   typedef struct packed {
      logic signed [31:0] gain;
      logic signed [31:0] offset;
      logic signed [31:0] corr;
      logic               gain_good;
      logic               corr_good;
   } entry_type;

   // Request operations.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_BLOCK_COUNT  = 3'd0,
      CSR_BLOCK_LENGTH = 3'd1,
      CSR_TOTAL_SLICES = 3'd2,
      CSR_FIRST_TIME   = 3'd3,
      CSR_LAST_TIME    = 3'd4,
      CSR_HAVE_TABLE   = 3'd5
   } csr_index_type;

   // Top-level sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SECT,
      ST_RST_LOAD,
      ST_CHECK,
      ST_NS_LOAD,
      ST_MATH,
      ST_WAIT,
      ST_FIN
   } state_type;

   // Interpolation unit states.
   typedef enum logic [2:0] {
      LERP_IDLE,
      LERP_MUL,
      LERP_PREP,
      LERP_DIV,
      LERP_DONE
   } lerp_state_type;

endpackage

// ===== rtl/bgi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bgi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== rtl/bgi_lerp.sv =====
// One interpolation channel: multiply, round, divide bit by bit, saturate.
module bgi_lerp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [31:0]                v0,
   input  logic signed [31:0]                v1,
   input  logic [bgi_pkg::M_BITS-1:0]        m,
   input  logic [bgi_pkg::DEN_BITS-1:0]      den,
   output logic                              done,
   output logic signed [31:0]                result
);

   bgi_pkg::lerp_state_type state_ff, state_in;

   logic signed [31:0]                   v0_ff, v0_in;
   logic signed [32:0]                   diff_ff, diff_in;
   logic [bgi_pkg::M_BITS-1:0]           m_ff, m_in;
   logic [bgi_pkg::DEN_BITS-1:0]         den_ff, den_in;
   logic signed [62:0]                   prod_ff, prod_in;
   logic                                 neg_ff, neg_in;
   logic [bgi_pkg::QUO_BITS-1:0]         num_ff, num_in;
   logic [bgi_pkg::QUO_BITS-1:0]         quo_ff, quo_in;
   logic [bgi_pkg::DEN_BITS-1:0]         rem_ff, rem_in;
   logic [bgi_pkg::STEP_BITS-1:0]        cnt_ff, cnt_in;

   logic [bgi_pkg::DEN_BITS:0]           trial;
   logic                                 ge;
   logic [62:0]                          mag;
   logic signed [63:0]                   sum;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bgi_pkg::LERP_IDLE: if (start) state_in = bgi_pkg::LERP_MUL;
         bgi_pkg::LERP_MUL:  state_in = bgi_pkg::LERP_PREP;
         bgi_pkg::LERP_PREP: state_in = bgi_pkg::LERP_DIV;
         bgi_pkg::LERP_DIV: begin
            if (cnt_ff == bgi_pkg::STEP_BITS'(bgi_pkg::QUO_BITS - 1)) begin
               state_in = bgi_pkg::LERP_DONE;
            end
         end
         bgi_pkg::LERP_DONE: state_in = bgi_pkg::LERP_IDLE;
         default:            state_in = bgi_pkg::LERP_IDLE;
      endcase
   end

   // One restoring division step.
   assign trial = {rem_ff, num_ff[bgi_pkg::QUO_BITS-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign mag   = prod_ff[62] ? 63'(-prod_ff) : 63'(prod_ff);

   // Datapath.
   always_comb begin
      v0_in   = v0_ff;
      diff_in = diff_ff;
      m_in    = m_ff;
      den_in  = den_ff;
      prod_in = prod_ff;
      neg_in  = neg_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      unique case (state_ff)
         bgi_pkg::LERP_IDLE: begin
            v0_in   = v0;
            diff_in = 33'(v1) - 33'(v0);
            m_in    = m;
            den_in  = den;
         end
         bgi_pkg::LERP_MUL: begin
            prod_in = 63'(diff_ff * $signed({1'b0, m_ff}));
         end
         bgi_pkg::LERP_PREP: begin
            neg_in = prod_ff[62];
            num_in = mag[bgi_pkg::QUO_BITS-1:0]
                     + bgi_pkg::QUO_BITS'(den_ff >> 1);
            quo_in = '0;
            rem_in = '0;
            cnt_in = '0;
         end
         bgi_pkg::LERP_DIV: begin
            rem_in = ge ? bgi_pkg::DEN_BITS'(trial - {1'b0, den_ff})
                        : trial[bgi_pkg::DEN_BITS-1:0];
            quo_in = {quo_ff[bgi_pkg::QUO_BITS-2:0], ge};
            num_in = {num_ff[bgi_pkg::QUO_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         bgi_pkg::LERP_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Add the rounded quotient back to the start value and saturate.
   always_comb begin
      sum = neg_ff ? (64'(v0_ff) - $signed({2'b00, quo_ff}))
                   : (64'(v0_ff) + $signed({2'b00, quo_ff}));
      if (sum > 64'sh7FFF_FFFF) begin
         result = 32'sh7FFF_FFFF;
      end else if (sum < -64'sh8000_0000) begin
         result = -32'sh8000_0000;
      end else begin
         result = sum[31:0];
      end
      done = (state_ff == bgi_pkg::LERP_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bgi_pkg::LERP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      v0_ff   <= v0_in;
      diff_ff <= diff_in;
      m_ff    <= m_in;
      den_ff  <= den_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== rtl/block_gain_interpolator.sv =====
// Top level of the block gain interpolator.
//
// Requests arrive on the req_ ports and are accepted when start is high
// and busy is low. A load request writes one block entry into the table
// memory in the accepting cycle and leaves busy low. A step request takes
// the current time slice, updates the section state and, for slices from
// first_time to last_time, puts one result on the rsp_ ports for exactly one
// cycle, marked by rsp_valid. The receiver cannot stall the block.
// A step that emits a result passes through ST_SECT, ST_CHECK, ST_MATH and
// ST_WAIT, which waits for the bit-serial dividers (62-bit quotient); a
// step before first_time ends in ST_FIN instead. ST_RST_LOAD at the start
// of a run and ST_NS_LOAD at a section boundary with a block to fetch read
// the table. Configuration is written through csr_write, csr_index and
// csr_data, and the user must do so only while the block is idle; the block
// does not enforce this. Reset restores the register defaults and sets the
// slice counter to zero; the table contents are undefined until loaded.
module block_gain_interpolator (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [9:0]          req_block_index,
   input  logic signed [31:0]  req_gain_value,
   input  logic signed [31:0]  req_offset_value,
   input  logic signed [31:0]  req_corr_value,
   input  logic                req_gain_good,
   input  logic                req_corr_good,
   output logic                rsp_valid,
   output logic [23:0]         rsp_slice_index,
   output logic signed [31:0]  rsp_gain_out,
   output logic signed [31:0]  rsp_offset_out,
   output logic signed [31:0]  rsp_corr_out,
   output logic                rsp_last_slice,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_data
);

   localparam int TB = bgi_pkg::TIME_BITS;
   localparam int XB = bgi_pkg::X2_BITS;
   localparam int BB = bgi_pkg::BLOCK_BITS;

   // Configuration registers.
   logic [10:0]  block_count_ff;
   logic [15:0]  block_length_ff;
   logic [23:0]  total_slices_ff;
   logic [23:0]  first_time_ff;
   logic [23:0]  last_time_ff;
   logic         have_table_ff;

   bgi_pkg::state_type state_ff, state_in;

   // Section state.
   logic [TB-1:0]          counter_ff, counter_in;
   logic [TB-1:0]          t_ff, t_in;
   logic [24:0]            nss_ff, nss_in;
   logic [10:0]            sec_num_ff, sec_num_in;
   bgi_pkg::entry_type     end0_ff, end0_in, end1_ff, end1_in;
   logic signed [XB-1:0]   start_x2_ff, start_x2_in;
   logic signed [XB-1:0]   end_x2_ff, end_x2_in;
   logic [24:0]            len_ff, len_in;

   // Result registers.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [23:0]            rsp_slice_ff, rsp_slice_in;
   logic signed [31:0]     rsp_gain_ff, rsp_gain_in;
   logic signed [31:0]     rsp_offset_ff, rsp_offset_in;
   logic signed [31:0]     rsp_corr_ff, rsp_corr_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                   ram_write;
   bgi_pkg::entry_type     ram_wdata;
   logic                   ram_read;
   logic [BB-1:0]          ram_raddr;
   logic [$bits(bgi_pkg::entry_type)-1:0] ram_rdata_raw;
   bgi_pkg::entry_type     ram_rdata;

   // Section step helpers.
   logic [10:0]            sn_inc;
   logic [10:0]            blk_idx;
   logic [24:0]            rest;
   logic [24:0]            dt;
   logic                   blk_ok;
   logic                   is_long;
   logic                   in_range;

   // Interpolation helpers.
   logic signed [XB:0]     m_raw;
   logic [bgi_pkg::M_BITS-1:0]   m_clip;
   logic [bgi_pkg::DEN_BITS-1:0] den;
   logic                   lerp_start;
   logic                   gain_done, offset_done, corr_done;
   logic signed [31:0]     gain_lerp, offset_lerp, corr_lerp;
   logic                   use_gain, use_corr;
   logic                   emit;
   logic                   last;

   assign busy = (state_ff != bgi_pkg::ST_IDLE);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff  <= 11'd1;
         block_length_ff <= 16'd1;
         total_slices_ff <= 24'd1;
         first_time_ff   <= '0;
         last_time_ff    <= '0;
         have_table_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            bgi_pkg::CSR_BLOCK_COUNT:  block_count_ff  <= csr_data[10:0];
            bgi_pkg::CSR_BLOCK_LENGTH: block_length_ff <= csr_data[15:0];
            bgi_pkg::CSR_TOTAL_SLICES: total_slices_ff <= csr_data;
            bgi_pkg::CSR_FIRST_TIME:   first_time_ff   <= csr_data;
            bgi_pkg::CSR_LAST_TIME:    last_time_ff    <= csr_data;
            bgi_pkg::CSR_HAVE_TABLE:   have_table_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Table memory: loads write in the accepting cycle.
   assign ram_write = start && !busy && (req_operation == bgi_pkg::OP_LOAD);
   assign ram_wdata = '{gain: req_gain_value, offset: req_offset_value,
                        corr: req_corr_value, gain_good: req_gain_good,
                        corr_good: req_corr_good};
   assign ram_rdata = bgi_pkg::entry_type'(ram_rdata_raw);

   bgi_ram #(
      .WIDTH ($bits(bgi_pkg::entry_type)),
      .DEPTH (bgi_pkg::MAX_BLOCKS)
   ) u_table (
      .clock      (clock),
      .write_en   (ram_write),
      .write_addr (req_block_index[BB-1:0]),
      .write_data (ram_wdata),
      .read_en    (ram_read),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata_raw)
   );

   // Section boundary arithmetic.
   always_comb begin
      sn_inc   = (sec_num_ff < bgi_pkg::SECTION_MAX) ? sec_num_ff + 11'd1 : sec_num_ff;
      blk_idx  = sn_inc - 11'd1;
      rest     = ({1'b0, total_slices_ff} > nss_ff) ? 25'({1'b0, total_slices_ff} - nss_ff)
                                                    : 25'd0;
      is_long  = (sn_inc == block_count_ff);
      in_range = (sn_inc <= block_count_ff);
      blk_ok   = in_range && (blk_idx < 11'(bgi_pkg::MAX_BLOCKS));
      dt       = is_long ? 25'((rest >> 1) + 25'(block_length_ff >> 2))
                         : 25'(block_length_ff);
   end

   // Interpolation inputs: doubled position inside the section. The position
   // never reaches the upper clamp of the slice range, so only the lower one
   // is needed.
   always_comb begin
      m_raw = $signed({1'b0, t_ff, 1'b0}) - (XB+1)'(start_x2_ff);
      if (m_raw < 0) begin
         m_clip = '0;
      end else begin
         m_clip = bgi_pkg::M_BITS'(m_raw);
      end
      den = {len_ff, 1'b0};
   end

   assign lerp_start = (state_ff == bgi_pkg::ST_MATH) && emit;

   bgi_lerp u_gain (
      .clock (clock), .reset (reset), .start (lerp_start),
      .v0 (end0_ff.gain), .v1 (end1_ff.gain), .m (m_clip), .den (den),
      .done (gain_done), .result (gain_lerp)
   );

   bgi_lerp u_offset (
      .clock (clock), .reset (reset), .start (lerp_start),
      .v0 (end0_ff.offset), .v1 (end1_ff.offset), .m (m_clip), .den (den),
      .done (offset_done), .result (offset_lerp)
   );

   bgi_lerp u_corr (
      .clock (clock), .reset (reset), .start (lerp_start),
      .v0 (end0_ff.corr), .v1 (end1_ff.corr), .m (m_clip), .den (den),
      .done (corr_done), .result (corr_lerp)
   );

   assign emit     = (t_ff >= first_time_ff);
   assign last     = (t_ff == last_time_ff);
   assign use_gain = end0_ff.gain_good && end1_ff.gain_good && (len_ff != '0);
   assign use_corr = end0_ff.corr_good && end1_ff.corr_good && (len_ff != '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bgi_pkg::ST_IDLE: begin
            if (start && (req_operation == bgi_pkg::OP_STEP)) state_in = bgi_pkg::ST_SECT;
         end
         bgi_pkg::ST_SECT: begin
            state_in = (t_ff == '0) ? bgi_pkg::ST_RST_LOAD : bgi_pkg::ST_CHECK;
         end
         bgi_pkg::ST_RST_LOAD: state_in = bgi_pkg::ST_CHECK;
         bgi_pkg::ST_CHECK: begin
            if ((25'(t_ff) == nss_ff) && blk_ok) begin
               state_in = bgi_pkg::ST_NS_LOAD;
            end else begin
               state_in = bgi_pkg::ST_MATH;
            end
         end
         bgi_pkg::ST_NS_LOAD: state_in = bgi_pkg::ST_MATH;
         bgi_pkg::ST_MATH:    state_in = emit ? bgi_pkg::ST_WAIT : bgi_pkg::ST_FIN;
         bgi_pkg::ST_WAIT:    if (gain_done) state_in = bgi_pkg::ST_IDLE;
         bgi_pkg::ST_FIN:     state_in = bgi_pkg::ST_IDLE;
         default:             state_in = bgi_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory reads per state.
   always_comb begin
      counter_in    = counter_ff;
      t_in          = t_ff;
      nss_in        = nss_ff;
      sec_num_in    = sec_num_ff;
      end0_in       = end0_ff;
      end1_in       = end1_ff;
      start_x2_in   = start_x2_ff;
      end_x2_in     = end_x2_ff;
      len_in        = len_ff;
      rsp_valid_in  = 1'b0;
      rsp_slice_in  = rsp_slice_ff;
      rsp_gain_in   = rsp_gain_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_corr_in   = rsp_corr_ff;
      rsp_last_in   = rsp_last_ff;
      ram_read      = 1'b0;
      ram_raddr     = '0;
      unique case (state_ff)
         bgi_pkg::ST_IDLE: begin
            t_in = counter_ff;
         end
         bgi_pkg::ST_SECT: begin
            // Start of a run: section one with block zero at its end.
            if (t_ff == '0) begin
               nss_in      = 25'(block_length_ff >> 1);
               sec_num_in  = 11'd1;
               end0_in     = '0;
               end_x2_in   = XB'($signed({1'b0, block_length_ff}) - 17'sd1);
               start_x2_in = XB'(-$signed({1'b0, block_length_ff}) - 18'sd1);
               len_in      = '0;
               ram_read    = 1'b1;
               ram_raddr   = '0;
            end
         end
         bgi_pkg::ST_RST_LOAD: begin
            end1_in = ram_rdata;
         end
         bgi_pkg::ST_CHECK: begin
            // Crossing a block centre: shift the ends and fetch the next block.
            if (25'(t_ff) == nss_ff) begin
               end0_in     = end1_ff;
               start_x2_in = end_x2_ff;
               sec_num_in  = sn_inc;
               end_x2_in   = end_x2_ff + $signed({(XB-26)'(0), dt, 1'b0});
               nss_in      = nss_ff + dt;
               len_in      = dt;
               ram_read    = blk_ok;
               ram_raddr   = blk_idx[BB-1:0];
               if (!blk_ok) begin
                  end1_in = '0;
               end
            end
         end
         bgi_pkg::ST_NS_LOAD: begin
            end1_in = ram_rdata;
         end
         bgi_pkg::ST_MATH: begin
         end
         bgi_pkg::ST_WAIT: begin
            // Pick interpolated, held or default values.
            if (gain_done) begin
               rsp_valid_in = 1'b1;
               rsp_slice_in = 24'(t_ff);
               rsp_last_in  = last;
               counter_in   = last ? '0 : t_ff + 1'b1;
               if (!have_table_ff) begin
                  rsp_gain_in   = bgi_pkg::Q_ONE;
                  rsp_offset_in = bgi_pkg::Q_ZERO;
                  rsp_corr_in   = bgi_pkg::Q_ONE;
               end else begin
                  rsp_gain_in   = use_gain ? gain_lerp :
                                  end0_ff.gain_good ? end0_ff.gain :
                                  end1_ff.gain_good ? end1_ff.gain : bgi_pkg::Q_ONE;
                  rsp_offset_in = use_gain ? offset_lerp :
                                  end0_ff.gain_good ? end0_ff.offset :
                                  end1_ff.gain_good ? end1_ff.offset : bgi_pkg::Q_ZERO;
                  rsp_corr_in   = use_corr ? corr_lerp :
                                  end0_ff.corr_good ? end0_ff.corr :
                                  end1_ff.corr_good ? end1_ff.corr : bgi_pkg::Q_ONE;
               end
            end
         end
         bgi_pkg::ST_FIN: begin
            counter_in = last ? '0 : t_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bgi_pkg::ST_IDLE;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff          <= t_in;
      nss_ff        <= nss_in;
      sec_num_ff    <= sec_num_in;
      end0_ff       <= end0_in;
      end1_ff       <= end1_in;
      start_x2_ff   <= start_x2_in;
      end_x2_ff     <= end_x2_in;
      len_ff        <= len_in;
      rsp_slice_ff  <= rsp_slice_in;
      rsp_gain_ff   <= rsp_gain_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_corr_ff   <= rsp_corr_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slice_index = rsp_slice_ff;
   assign rsp_gain_out    = rsp_gain_ff;
   assign rsp_offset_out  = rsp_offset_ff;
   assign rsp_corr_out    = rsp_corr_ff;
   assign rsp_last_slice  = rsp_last_ff;

   // A result strobe lasts one cycle and never repeats back to back.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe repeated");

   // An accepted step request always makes the block busy.
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == bgi_pkg::OP_STEP) |=> busy)
      else $error("step request not taken up");

   // The three interpolation channels run in lockstep.
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      (gain_done == offset_done) && (gain_done == corr_done))
      else $error("interpolation channels out of step");

   // No result is emitted for a slice before first_time.
   a_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_slice_ff >= first_time_ff))
      else $error("result emitted before first slice");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the block gain interpolator.
`timescale 1ns / 100ps

module tb_top;

   localparam longint unsigned TIME_MASK = (64'd1 << bgi_pkg::TIME_BITS) - 1;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_PER_PHASE = 45;

   // One emitted slice.
   typedef struct packed {
      logic [23:0]        slice;
      logic signed [31:0] gain;
      logic signed [31:0] offset;
      logic signed [31:0] corr;
      logic               last;
   } slice_result_type;

   // One row of the directed request list.
   typedef struct packed {
      bgi_pkg::op_type    op;
      logic [9:0]         index;
      logic signed [31:0] gain;
      logic signed [31:0] offset;
      logic signed [31:0] corr;
      logic               gain_good;
      logic               corr_good;
      logic               typed;
   } directed_row_type;

   // One setting of all six registers.
   typedef struct packed {
      logic [10:0] count;
      logic [15:0] length;
      logic [23:0] total;
      logic [23:0] first;
      logic [23:0] last;
      logic        table_on;
   } setting_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_operation;
   logic [9:0]         req_block_index;
   logic signed [31:0] req_gain_value;
   logic signed [31:0] req_offset_value;
   logic signed [31:0] req_corr_value;
   logic               req_gain_good;
   logic               req_corr_good;
   logic               rsp_valid;
   logic [23:0]        rsp_slice_index;
   logic signed [31:0] rsp_gain_out;
   logic signed [31:0] rsp_offset_out;
   logic signed [31:0] rsp_corr_out;
   logic               rsp_last_slice;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [23:0]        csr_data;

   block_gain_interpolator dut (.*);

   // Predictor state: registers, table and section tracking.
   logic [10:0]         cfg_count;
   logic [15:0]         cfg_length;
   logic [23:0]         cfg_total;
   logic [23:0]         cfg_first;
   logic [23:0]         cfg_last;
   logic                cfg_table_on;
   bgi_pkg::entry_type  block_table [bgi_pkg::MAX_BLOCKS];
   bit                  block_written [bgi_pkg::MAX_BLOCKS];
   longint unsigned     slice_count;
   longint unsigned     next_start;
   int unsigned         section_no;
   bgi_pkg::entry_type  section_end [2];
   longint              start_x2;
   longint              end_x2;
   longint unsigned     section_len;

   slice_result_type  expected_slices [$];
   int                error_count;
   int                cycle_count;
   int                burst_left;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** block_gain_interpolator: FAILED **");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Section state bookkeeping.
   function automatic void fetch_end(input longint unsigned blk);
      if (blk < bgi_pkg::MAX_BLOCKS) section_end[1] = block_table[blk];
      else section_end[1] = '0;
   endfunction

   function automatic void restart_run();
      next_start = cfg_length / 2;
      section_no = 1;
      section_end[0] = '0;
      fetch_end(0);
      end_x2 = longint'(cfg_length) - 1;
      start_x2 = end_x2 - 2 * longint'(cfg_length);
      section_len = 0;
   endfunction

   function automatic void advance_section();
      longint unsigned dt;
      longint unsigned rest;
      section_end[0] = section_end[1];
      start_x2 = end_x2;
      if (section_no < bgi_pkg::SECTION_MAX) section_no++;
      if (section_no < cfg_count) begin
         fetch_end(section_no - 1);
         dt = cfg_length;
      end else if (section_no == cfg_count) begin
         rest = (cfg_total > next_start) ? cfg_total - next_start : 0;
         fetch_end(section_no - 1);
         dt = rest / 2 + cfg_length / 4;
      end else begin
         fetch_end(bgi_pkg::MAX_BLOCKS);
         dt = cfg_length;
      end
      end_x2 += 2 * longint'(dt);
      next_start += dt;
      section_len = dt;
   endfunction

   // Linear blend of the two section ends, rounded half away from zero.
   function automatic logic signed [31:0] blend(input logic signed [31:0] v0,
         input bit ok0, input logic signed [31:0] v1, input bit ok1,
         input logic signed [31:0] dflt, input longint unsigned t);
      longint m;
      longint num;
      longint r;
      longint unsigned den;
      longint unsigned mag;
      longint unsigned q;
      if (ok0 && ok1 && section_len > 0) begin
         m = 2 * longint'(t) - start_x2;
         if (m < 0) m = 0;
         if (m > (64'sd1 <<< 28)) m = 64'sd1 <<< 28;
         num = (longint'(v1) - longint'(v0)) * m;
         den = 2 * section_len;
         mag = (num < 0) ? longint'(-num) : num;
         q = (mag + den / 2) / den;
         r = longint'(v0) + ((num < 0) ? -longint'(q) : longint'(q));
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r[31:0];
      end
      if (ok0) return v0;
      if (ok1) return v1;
      return dflt;
   endfunction

   // Advance one slice; returns 1 with the slice values when one is emitted.
   function automatic bit step_slice(output slice_result_type res);
      longint unsigned t;
      bit at_last;
      bit emitted;
      t = slice_count & TIME_MASK;
      if (t == 0) restart_run();
      if (t == next_start) advance_section();
      at_last = (t == cfg_last);
      emitted = (t >= cfg_first);
      res = '0;
      if (emitted) begin
         res.slice = t[23:0];
         res.gain = bgi_pkg::Q_ONE;
         res.offset = bgi_pkg::Q_ZERO;
         res.corr = bgi_pkg::Q_ONE;
         res.last = at_last;
         if (cfg_table_on) begin
            res.gain = blend(section_end[0].gain, section_end[0].gain_good,
               section_end[1].gain, section_end[1].gain_good, bgi_pkg::Q_ONE, t);
            res.offset = blend(section_end[0].offset, section_end[0].gain_good,
               section_end[1].offset, section_end[1].gain_good, bgi_pkg::Q_ZERO, t);
            res.corr = blend(section_end[0].corr, section_end[0].corr_good,
               section_end[1].corr, section_end[1].corr_good, bgi_pkg::Q_ONE, t);
         end
      end
      slice_count = at_last ? 0 : ((t + 1) & TIME_MASK);
      return emitted;
   endfunction

   // Table entries the next slice will read (-1 where none).
   function automatic void blocks_read_next(output int first_blk, output int second_blk);
      longint unsigned t;
      longint unsigned ns;
      int unsigned sn;
      first_blk = -1;
      second_blk = -1;
      t = slice_count & TIME_MASK;
      ns = next_start;
      sn = section_no;
      if (t == 0) begin
         first_blk = 0;
         ns = cfg_length / 2;
         sn = 1;
      end
      if (t == ns) begin
         if (sn < bgi_pkg::SECTION_MAX) sn++;
         if (sn <= cfg_count) second_blk = sn - 1;
      end
   endfunction

   // Result checker.
   always @(posedge clock) begin
      slice_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_slices.size() == 0) begin
            report($sformatf("unexpected slice %0d", rsp_slice_index));
         end else begin
            exp_r = expected_slices.pop_front();
            if (rsp_slice_index !== exp_r.slice)
               report($sformatf("slice %0d, want %0d", rsp_slice_index, exp_r.slice));
            if (rsp_gain_out !== exp_r.gain)
               report($sformatf("slice %0d gain %0d, want %0d", exp_r.slice,
                  rsp_gain_out, exp_r.gain));
            if (rsp_offset_out !== exp_r.offset)
               report($sformatf("slice %0d offset %0d, want %0d", exp_r.slice,
                  rsp_offset_out, exp_r.offset));
            if (rsp_corr_out !== exp_r.corr)
               report($sformatf("slice %0d corr %0d, want %0d", exp_r.slice,
                  rsp_corr_out, exp_r.corr));
            if (rsp_last_slice !== exp_r.last)
               report($sformatf("slice %0d last %0b, want %0b", exp_r.slice,
                  rsp_last_slice, exp_r.last));
         end
      end
   end

   // Sender idling: bursts of requests with random gaps. Called at a falling edge.
   task automatic sender_pause();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // Drive one request at a falling edge and return at the falling edge after acceptance.
   task automatic send_request(input directed_row_type row);
      slice_result_type res;
      sender_pause();
      start <= 1'b1;
      req_operation <= row.op;
      req_block_index <= row.index;
      req_gain_value <= row.gain;
      req_offset_value <= row.offset;
      req_corr_value <= row.corr;
      req_gain_good <= row.gain_good;
      req_corr_good <= row.corr_good;
      // Busy only changes at a rising edge, so the falling edge tells whether
      // the next rising edge accepts the request.
      while (busy) @(negedge clock);
      @(posedge clock);
      if (row.op == bgi_pkg::OP_LOAD) begin
         block_table[row.index] = '{row.gain, row.offset, row.corr,
            row.gain_good, row.corr_good};
         block_written[row.index] = 1'b1;
      end else if (step_slice(res)) begin
         // Rows read straight off the reset defaults carry their own expectation.
         if (row.typed) res = '{24'd0, bgi_pkg::Q_ONE, bgi_pkg::Q_ZERO, bgi_pkg::Q_ONE, 1'b1};
         expected_slices.push_back(res);
      end
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] random_q();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sh0;
         3: return $signed($urandom_range(0, 262144)) - 32'sd131072;
         default: return $urandom;
      endcase
   endfunction

   function automatic directed_row_type random_load(input int blk);
      directed_row_type row;
      row.op = bgi_pkg::OP_LOAD;
      row.index = blk[9:0];
      row.gain = random_q();
      row.offset = random_q();
      row.corr = random_q();
      row.gain_good = ($urandom_range(0, 3) != 0);
      row.corr_good = ($urandom_range(0, 3) != 0);
      row.typed = 1'b0;
      return row;
   endfunction

   // A step request, loading first any entry it would read while still unwritten.
   task automatic send_step();
      int b0;
      int b1;
      directed_row_type row;
      blocks_read_next(b0, b1);
      if (b0 >= 0 && !block_written[b0]) send_request(random_load(b0));
      if (b1 >= 0 && !block_written[b1]) send_request(random_load(b1));
      row = '0;
      row.op = bgi_pkg::OP_STEP;
      row.index = 10'($urandom);
      row.gain = $urandom;
      row.offset = $urandom;
      row.corr = $urandom;
      row.gain_good = 1'($urandom);
      row.corr_good = 1'($urandom);
      send_request(row);
   endtask

   task automatic write_register(input bgi_pkg::csr_index_type idx,
         input logic [23:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         bgi_pkg::CSR_BLOCK_COUNT:  cfg_count = value[10:0];
         bgi_pkg::CSR_BLOCK_LENGTH: cfg_length = value[15:0];
         bgi_pkg::CSR_TOTAL_SLICES: cfg_total = value;
         bgi_pkg::CSR_FIRST_TIME:   cfg_first = value;
         bgi_pkg::CSR_LAST_TIME:    cfg_last = value;
         bgi_pkg::CSR_HAVE_TABLE:   cfg_table_on = value[0];
         default: ;
      endcase
   endtask

   // Let every outstanding slice arrive, then let a silent step finish.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (expected_slices.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(input setting_type s);
      write_register(bgi_pkg::CSR_BLOCK_COUNT, {13'd0, s.count});
      write_register(bgi_pkg::CSR_BLOCK_LENGTH, {8'd0, s.length});
      write_register(bgi_pkg::CSR_TOTAL_SLICES, s.total);
      write_register(bgi_pkg::CSR_FIRST_TIME, s.first);
      write_register(bgi_pkg::CSR_LAST_TIME, s.last);
      write_register(bgi_pkg::CSR_HAVE_TABLE, {23'd0, s.table_on});
   endtask

   function automatic setting_type random_setting();
      setting_type s;
      s.count = ($urandom_range(0, 4) == 0) ? 11'd1024 : 11'($urandom_range(1, 8));
      s.length = ($urandom_range(0, 5) == 0) ? 16'd65535 : 16'($urandom_range(1, 12));
      s.total = 24'($urandom_range(1, 80));
      s.first = 24'($urandom_range(0, 10));
      s.last = s.first + 24'($urandom_range(0, 60));
      s.table_on = ($urandom_range(0, 4) != 0);
      return s;
   endfunction

   initial begin
      directed_row_type directed_rows [$];
      setting_type phases [$];
      directed_row_type row;
      cycle_count = 0;
      error_count = 0;
      burst_left = 0;
      reset = 1'b1;
      start = 1'b0;
      req_operation = bgi_pkg::OP_LOAD;
      req_block_index = '0;
      req_gain_value = '0;
      req_offset_value = '0;
      req_corr_value = '0;
      req_gain_good = 1'b0;
      req_corr_good = 1'b0;
      csr_write = 1'b0;
      csr_index = bgi_pkg::CSR_BLOCK_COUNT;
      csr_data = '0;
      cfg_count = 11'd1;
      cfg_length = 16'd1;
      cfg_total = 24'd1;
      cfg_first = 24'd0;
      cfg_last = 24'd0;
      cfg_table_on = 1'b0;
      for (int i = 0; i < bgi_pkg::MAX_BLOCKS; i++) begin
         block_table[i] = '0;
         block_written[i] = 1'b0;
      end
      slice_count = 0;
      restart_run();

      // Directed requests at the reset settings: table loads, some at the extremes,
      // and steps that each wrap at last_time = 0 and give defaults, no table in use.
      directed_rows.push_back('{bgi_pkg::OP_LOAD, 10'd0, 32'sh7fffffff, 32'sh80000000,
         32'sh7fffffff, 1'b1, 1'b1, 1'b0});
      directed_rows.push_back('{bgi_pkg::OP_LOAD, 10'd1, 32'sh80000000, 32'sh7fffffff,
         32'sh80000000, 1'b1, 1'b1, 1'b0});
      directed_rows.push_back('{bgi_pkg::OP_LOAD, 10'd1023, 32'sh0, 32'shffffffff,
         32'sh00010000, 1'b0, 1'b1, 1'b0});
      directed_rows.push_back('{bgi_pkg::OP_STEP, 10'd0, 32'sh0, 32'sh0, 32'sh0,
         1'b0, 1'b0, 1'b1});
      directed_rows.push_back('{bgi_pkg::OP_STEP, 10'h3ff, 32'shffffffff, 32'shffffffff,
         32'shffffffff, 1'b1, 1'b1, 1'b1});
      directed_rows.push_back('{bgi_pkg::OP_LOAD, 10'd2, 32'sh00020000, 32'sh00008000,
         32'shffff0000, 1'b1, 1'b0, 1'b0});
      directed_rows.push_back('{bgi_pkg::OP_LOAD, 10'd3, 32'shfffe0000, 32'sh00000001,
         32'sh00004000, 1'b0, 1'b0, 1'b0});
      directed_rows.push_back('{bgi_pkg::OP_STEP, 10'd5, 32'sh1, 32'sh2, 32'sh3,
         1'b0, 1'b1, 1'b1});

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) send_request(directed_rows[i]);
      drain();

      // Settings: plain interpolation with a long closing section, late first
      // slice with timing past the series end, the smallest series, the largest
      // values, no table, a second late first slice, then random ones.
      phases.push_back('{11'd4, 16'd4, 24'd16, 24'd0, 24'd15, 1'b1});
      phases.push_back('{11'd3, 16'd5, 24'd12, 24'd3, 24'd30, 1'b1});
      phases.push_back('{11'd1, 16'd1, 24'd1, 24'd0, 24'd0, 1'b1});
      phases.push_back('{11'd1024, 16'd65535, 24'd16777215, 24'd0, 24'd16777214, 1'b1});
      phases.push_back('{11'd2, 16'd2, 24'd5, 24'd0, 24'd6, 1'b0});
      phases.push_back('{11'd2, 16'd3, 24'd9, 24'd4, 24'd8, 1'b1});
      repeat (5) phases.push_back(random_setting());

      foreach (phases[p]) begin
         apply_setting(phases[p]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Mostly steps; some loads rewrite entries this setting reads.
            if ($urandom_range(0, 4) == 0) begin
               row = random_load($urandom_range(0, (phases[p].count > 16) ? 15 :
                  phases[p].count - 1));
               send_request(row);
            end else begin
               send_step();
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("** block_gain_interpolator: PASSED **");
      end else begin
         $display("** block_gain_interpolator: FAILED **");
      end
      $finish;
   end

endmodule
